/* rtl/core/bsfns_pkg.sv */
// ----------------------------------------------------------------------------
// Bit store package
// Shared widths, request codes and the lowest-set-bit encoder used by the
// bit store with find-next-set-bit.
// ----------------------------------------------------------------------------
package bsfns_pkg;

    // Default store geometry.
    localparam int WORD_COUNT_DEF = 64;
    localparam int WORD_BITS_DEF  = 64;

    // Field widths of the request and response channels.
    localparam int REQ_W    = 3;
    localparam int BITPOS_W = 16;
    localparam int POS_W    = 12;
    localparam int CNT_W    = 13;

    // The widest word and the index of a bit within it.
    localparam int MAXW_BITS = 64;
    localparam int LOW_W     = 6;

    // The summary scan looks at this many words per cycle.
    localparam int SCAN_LANES = 32;
    localparam int LANE_W     = 5;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_SET    = 3'd0,
        REQ_CLEAR  = 3'd1,
        REQ_TEST   = 3'd2,
        REQ_FIRST  = 3'd3,
        REQ_NEXT   = 3'd4,
        REQ_COUNT  = 3'd5,
        REQ_SINGLE = 3'd6
    } t_req_type;

    // Index of the lowest set bit; zero when no bit is set.
    // The lowest one is isolated first, then each index bit is an OR.
    function automatic logic [LOW_W-1:0] low_one(input logic [MAXW_BITS-1:0] x);
        logic [MAXW_BITS-1:0] iso;
        logic [LOW_W-1:0]     idx;
        iso = x & (~x + MAXW_BITS'(1));
        idx = '0;
        for (int b = 0; b < LOW_W; b++) begin
            for (int i = 0; i < MAXW_BITS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    idx[b] = idx[b] | iso[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/bsfns_if.sv */
// ----------------------------------------------------------------------------
// Bit store channels
// Valid/ready channels for requests into the bit store and its responses.
// ----------------------------------------------------------------------------
interface bsfns_req_if;
    import bsfns_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [BITPOS_W-1:0] bit_position;

    modport source (output valid, req_type, bit_position, input ready);
    modport sink   (input valid, req_type, bit_position, output ready);
endinterface

interface bsfns_rsp_if;
    import bsfns_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] set_count;
    logic             out_of_range;

    modport source (output valid, found, position, set_count, out_of_range, input ready);
    modport sink   (input valid, found, position, set_count, out_of_range, output ready);
endinterface

/* rtl/core/bsfns_ram.sv */
// ----------------------------------------------------------------------------
// Bit store RAM
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bsfns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/bitmap_store_find_next_set_unit.sv */
// ----------------------------------------------------------------------------
// Bit store with find-next-set-bit
// A fixed-capacity bit set in a word RAM with a per-word nonzero summary.
// Requests set, clear or test one bit, find the first or next set bit, report
// the set-bit count, or report the position of the only set bit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                   Handshake
//  i_req     in   req_type, bit_position                    valid/ready
//  o_rsp     out  found, position, set_count, out_of_range  valid/ready
//
// Set, clear, test and find next split the position by reciprocal multiply,
// then read and use the word; find first and singleton start at the read;
// count, unused codes and positions beyond capacity skip to the response.
// A search past its first word scans 32-word summary chunks and reads each
// further word. After reset a clearing pass over every word keeps ready low.
// A stalled response holds the next request in its last state until it is taken.
// ----------------------------------------------------------------------------
module bitmap_store_find_next_set_unit #(
    parameter int WORD_COUNT = bsfns_pkg::WORD_COUNT_DEF,
    parameter int WORD_BITS  = bsfns_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsfns_req_if.sink   i_req,
    bsfns_rsp_if.source o_rsp
);
    import bsfns_pkg::*;

    // Geometry.
    localparam int CAPACITY = WORD_COUNT * WORD_BITS;
    localparam int AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW       = $clog2(WORD_BITS);
    localparam int OPW      = BITPOS_W + 1;
    localparam int NCHUNK   = (WORD_COUNT + SCAN_LANES - 1) / SCAN_LANES;
    localparam int CW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int GW       = CW + LANE_W;
    localparam int NZ_W     = NCHUNK * SCAN_LANES;

    // Reciprocal of the word size for the position split.
    localparam int RSHIFT   = 24;
    localparam int RECIP    = ((2 ** RSHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RCP_W    = $clog2(RECIP + 1);
    localparam int PROD_W   = OPW + RCP_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_DIV2  = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_USE   = 8'b0010_0000,
        S_SCAN  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Control and datapath registers.
    t_state              r_state,      n_state;
    logic [REQ_W-1:0]    r_req,        n_req;
    logic [OPW-1:0]      r_oper,       n_oper;
    logic [PROD_W-1:0]   r_prod,       n_prod;
    logic [AW-1:0]       r_word,       n_word;
    logic [BW-1:0]       r_bit,        n_bit;
    logic [AW-1:0]       r_clr,        n_clr;
    logic [CW-1:0]       r_chunk,      n_chunk;
    logic [GW-1:0]       r_scan_from,  n_scan_from;
    logic                r_single,     n_single;
    logic [WORD_COUNT-1:0] r_nz,       n_nz;
    logic [CNT_W-1:0]    r_ones,       n_ones;
    logic                r_res_found,  n_res_found;
    logic [POS_W-1:0]    r_res_pos,    n_res_pos;
    logic                r_res_oor,    n_res_oor;
    logic                r_out_valid,  n_out_valid;
    logic                r_out_found,  n_out_found;
    logic [POS_W-1:0]    r_out_pos,    n_out_pos;
    logic [CNT_W-1:0]    r_out_cnt,    n_out_cnt;
    logic                r_out_oor,    n_out_oor;

    // RAM port signals.
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_rdata;

    bsfns_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_word),
        .o_rdata (w_rdata)
    );

    // Handshake.
    logic w_accept;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.position     = r_out_pos;
    assign o_rsp.set_count    = r_out_cnt;
    assign o_rsp.out_of_range = r_out_oor;

    // Sequencer and shared datapath.
    always_comb begin
        logic [OPW-1:0]        v_oper;
        logic                  v_inside;
        logic [OPW-1:0]        v_quot;
        logic [OPW-1:0]        v_rem;
        logic [WORD_BITS-1:0]  v_sel;
        logic [WORD_BITS-1:0]  v_word;
        logic [LOW_W-1:0]      v_lo;
        logic [POS_W-1:0]      v_pos;
        logic                  v_last;
        logic [GW-1:0]         v_next_from;
        logic [NZ_W-1:0]       v_nz_pad;
        logic [SCAN_LANES-1:0] v_lanes;
        logic [SCAN_LANES-1:0] v_qual;
        logic [LOW_W-1:0]      v_lane;
        logic [GW-1:0]         v_hit;

        n_state     = r_state;
        n_req       = r_req;
        n_oper      = r_oper;
        n_prod      = r_prod;
        n_word      = r_word;
        n_bit       = r_bit;
        n_clr       = r_clr;
        n_chunk     = r_chunk;
        n_scan_from = r_scan_from;
        n_single    = r_single;
        n_nz        = r_nz;
        n_ones      = r_ones;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_res_oor   = r_res_oor;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;
        n_out_cnt   = r_out_cnt;
        n_out_oor   = r_out_oor;
        w_we        = 1'b0;
        w_waddr     = r_word;
        w_wdata     = '0;

        // Incoming position; find next starts one past it.
        if (i_req.req_type == REQ_NEXT) begin
            v_oper = OPW'(i_req.bit_position) + OPW'(1);
        end else begin
            v_oper = OPW'(i_req.bit_position);
        end
        v_inside = (v_oper < OPW'(CAPACITY));

        // Word and bit split by reciprocal multiply, with one correction.
        v_quot = OPW'(r_prod >> RSHIFT);
        v_rem  = r_oper - OPW'(v_quot * OPW'(WORD_BITS));
        if (v_rem >= OPW'(WORD_BITS)) begin
            v_quot = v_quot + OPW'(1);
            v_rem  = v_rem - OPW'(WORD_BITS);
        end

        // Word just read, masked from the start bit on.
        v_sel  = WORD_BITS'(1) << r_bit;
        v_word = w_rdata & ({WORD_BITS{1'b1}} << r_bit);
        v_lo   = low_one(MAXW_BITS'(v_word));
        v_pos  = POS_W'(32'(r_word) * 32'(WORD_BITS) + 32'(v_lo));
        v_last = (r_word == AW'(WORD_COUNT - 1));
        v_next_from = GW'(r_word) + GW'(1);

        // One chunk of the nonzero summary, masked below the scan start.
        v_nz_pad = NZ_W'(r_nz);
        v_lanes  = v_nz_pad[r_chunk * SCAN_LANES +: SCAN_LANES];
        for (int l = 0; l < SCAN_LANES; l++) begin
            v_qual[l] = v_lanes[l] && ({r_chunk, LANE_W'(l)} >= r_scan_from);
        end
        v_lane = low_one(MAXW_BITS'(v_qual));
        v_hit  = {r_chunk, v_lane[LANE_W-1:0]};

        // The response register drains when it is taken.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req       = i_req.req_type;
                    n_oper      = v_oper;
                    n_word      = '0;
                    n_bit       = '0;
                    n_single    = 1'b0;
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_res_oor   = 1'b0;
                    unique case (i_req.req_type)
                        REQ_SET, REQ_CLEAR, REQ_TEST, REQ_NEXT: begin
                            if (v_inside) begin
                                n_state = S_DIV1;
                            end else begin
                                n_res_oor = (i_req.req_type == REQ_SET);
                                n_state   = S_DONE;
                            end
                        end
                        REQ_FIRST, REQ_SINGLE: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV1: begin
                n_prod  = PROD_W'(r_oper) * PROD_W'(RECIP);
                n_state = S_DIV2;
            end
            S_DIV2: begin
                n_word  = AW'(v_quot);
                n_bit   = BW'(v_rem);
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_USE;
            end
            S_USE: begin
                n_state = S_DONE;
                unique case (r_req)
                    REQ_SET: begin
                        if ((w_rdata & v_sel) == '0) begin
                            w_we         = 1'b1;
                            w_wdata      = w_rdata | v_sel;
                            n_nz[r_word] = 1'b1;
                            n_ones       = r_ones + CNT_W'(1);
                        end
                    end
                    REQ_CLEAR: begin
                        if ((w_rdata & v_sel) != '0) begin
                            w_we         = 1'b1;
                            w_wdata      = w_rdata & ~v_sel;
                            n_nz[r_word] = |(w_rdata & ~v_sel);
                            n_ones       = r_ones - CNT_W'(1);
                        end
                    end
                    REQ_TEST: begin
                        n_res_found = |(w_rdata & v_sel);
                    end
                    REQ_FIRST, REQ_NEXT: begin
                        if (v_word != '0) begin
                            n_res_found = 1'b1;
                            n_res_pos   = v_pos;
                        end else if (!v_last) begin
                            n_scan_from = v_next_from;
                            n_chunk     = CW'(v_next_from >> LANE_W);
                            n_state     = S_SCAN;
                        end
                    end
                    REQ_SINGLE: begin
                        if (v_word != '0) begin
                            // A lone bit in this word: look for any other nonzero word.
                            if ((v_word & (v_word - WORD_BITS'(1))) == '0) begin
                                n_res_pos = v_pos;
                                n_single  = 1'b1;
                                if (v_last) begin
                                    n_res_found = 1'b1;
                                end else begin
                                    n_scan_from = v_next_from;
                                    n_chunk     = CW'(v_next_from >> LANE_W);
                                    n_state     = S_SCAN;
                                end
                            end
                        end else if (!v_last) begin
                            n_scan_from = v_next_from;
                            n_chunk     = CW'(v_next_from >> LANE_W);
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        n_res_found = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                if (v_qual != '0) begin
                    if (r_single) begin
                        // A second nonzero word: more than one bit is set.
                        n_res_pos = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_word  = AW'(v_hit);
                        n_bit   = '0;
                        n_state = S_RD;
                    end
                end else if (r_chunk == CW'(NCHUNK - 1)) begin
                    n_res_found = r_single;
                    n_state     = S_DONE;
                end else begin
                    n_chunk = r_chunk + CW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_pos   = r_res_found ? r_res_pos : '0;
                    n_out_cnt   = r_ones;
                    n_out_oor   = r_res_oor;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_nz        <= '0;
            r_ones      <= '0;
            r_single    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_nz        <= n_nz;
            r_ones      <= n_ones;
            r_single    <= n_single;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_oper      <= n_oper;
        r_prod      <= n_prod;
        r_word      <= n_word;
        r_bit       <= n_bit;
        r_chunk     <= n_chunk;
        r_scan_from <= n_scan_from;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_res_oor   <= n_res_oor;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
        r_out_cnt   <= n_out_cnt;
        r_out_oor   <= n_out_oor;
    end

`ifndef NO_ASSERTIONS
    // The summary bit of a word agrees with the word as read from the RAM.
    a_summary_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_USE) |-> (r_nz[r_word] == (w_rdata != '0)))
        else $error("nonzero summary disagrees with word contents");

    // Setting a new bit raises the count by one.
    a_set_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_USE && r_req == REQ_SET && w_we)
        |=> (r_ones == $past(r_ones) + CNT_W'(1)))
        else $error("set-bit count did not increment on set");

    // Clearing a set bit lowers the count by one.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_USE && r_req == REQ_CLEAR && w_we)
        |=> (r_ones == $past(r_ones) - CNT_W'(1)))
        else $error("set-bit count did not decrement on clear");

    // A summary scan always starts at a word inside the store.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_from <= GW'(WORD_COUNT - 1)))
        else $error("summary scan starts beyond the last word");
`endif

endmodule
